### hw/rtl/cic_pkg.sv
`default_nettype none

package cic_pkg;

    localparam int DATA_W = 32;
    localparam int KIND_W = 3;
    localparam int CNT_W  = $clog2(DATA_W);

    // operator codes carried on the input tuser
    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD   = 3'd0,
        KIND_ADD    = 3'd1,
        KIND_SUB    = 3'd2,
        KIND_MUL    = 3'd3,
        KIND_DIV    = 3'd4,
        KIND_EQUALS = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_FIX,
        ST_EMIT
    } t_state;

    typedef enum logic [2:0] {
        DP_NONE,
        DP_LOAD,
        DP_ADD,
        DP_SUB,
        DP_MUL,
        DP_DIV_INIT,
        DP_DIV_STEP,
        DP_DIV_FIX
    } t_dp_op;

    typedef struct packed {
        logic   capture;
        t_dp_op op;
        logic   emit;
        logic   emit_err;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  opnd_zero;
        logic  div_last;
        logic  out_free;
    } t_status;

endpackage

`default_nettype wire

### hw/rtl/cic_ctrl.sv
`default_nettype none

module cic_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire cic_pkg::t_status i_status,
    output cic_pkg::t_cmd         o_cmd
);
    import cic_pkg::*;

    t_state r_state, n_state;
    logic   r_active, n_active;
    logic   r_err, n_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_active <= 1'b0;
            r_err    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_err    <= n_err;
        end
    end

    always_comb begin
        n_state         = r_state;
        n_active        = r_active;
        n_err           = r_err;
        o_ready         = 1'b0;
        o_cmd.capture   = 1'b0;
        o_cmd.op        = DP_NONE;
        o_cmd.emit      = 1'b0;
        o_cmd.emit_err  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
                priority if (i_status.kind == KIND_LOAD) begin
                    o_cmd.op = DP_LOAD;
                    n_active = 1'b1;
                end else if (!r_active) begin
                    // closed expression: item dropped
                    o_cmd.op = DP_NONE;
                end else begin
                    unique case (i_status.kind)
                        KIND_ADD: o_cmd.op = DP_ADD;
                        KIND_SUB: o_cmd.op = DP_SUB;
                        KIND_MUL: o_cmd.op = DP_MUL;
                        KIND_DIV: begin
                            if (i_status.opnd_zero) begin
                                n_err   = 1'b1;
                                n_state = ST_EMIT;
                            end else begin
                                o_cmd.op = DP_DIV_INIT;
                                n_state  = ST_DIV;
                            end
                        end
                        KIND_EQUALS: begin
                            n_err   = 1'b0;
                            n_state = ST_EMIT;
                        end
                        default: begin
                            n_err   = 1'b1;
                            n_state = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                o_cmd.op = DP_DIV_STEP;
                if (i_status.div_last) begin
                    n_state = ST_FIX;
                end
            end
            ST_FIX: begin
                o_cmd.op = DP_DIV_FIX;
                n_state  = ST_IDLE;
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_err = r_err;
                    n_active       = 1'b0;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // a result only leaves while an expression is open
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> r_active)
        else $error("result emitted with no open expression");

    // an accepted item is executed in the next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == ST_EXEC))
        else $error("accepted item not executed");

    // the last quotient step leads to the sign fix-up
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && i_status.div_last) |=> (r_state == ST_FIX))
        else $error("divide did not finish with sign fix-up");

endmodule

`default_nettype wire

### hw/rtl/cic_dp.sv
`default_nettype none

module cic_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic [cic_pkg::KIND_W-1:0]          i_kind,
    input  wire logic signed [cic_pkg::DATA_W-1:0]   i_operand,
    input  wire cic_pkg::t_cmd                       i_cmd,
    output cic_pkg::t_status                         o_status,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic signed [cic_pkg::DATA_W-1:0]        o_value,
    output logic                                     o_error
);
    import cic_pkg::*;

    logic [KIND_W-1:0] r_kind;
    logic [DATA_W-1:0] r_opnd;
    logic [DATA_W-1:0] r_acc, n_acc;
    logic [DATA_W-1:0] r_rem, r_quo, r_den;
    logic              r_neg;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_value;
    logic              r_out_err;

    logic [2*DATA_W-1:0] prod;
    logic [DATA_W-1:0]   acc_mag, opnd_mag;
    logic [DATA_W:0]     rem_sh, diff;
    logic                fits;

    assign prod     = r_acc * r_opnd;
    assign acc_mag  = r_acc[DATA_W-1] ? (~r_acc + 1'b1) : r_acc;
    assign opnd_mag = r_opnd[DATA_W-1] ? (~r_opnd + 1'b1) : r_opnd;
    assign rem_sh   = {r_rem, r_quo[DATA_W-1]};
    assign diff     = rem_sh - {1'b0, r_den};
    assign fits     = !diff[DATA_W];

    always_comb begin
        n_acc = r_acc;
        unique case (i_cmd.op)
            DP_LOAD:    n_acc = r_opnd;
            DP_ADD:     n_acc = r_acc + r_opnd;
            DP_SUB:     n_acc = r_acc - r_opnd;
            DP_MUL:     n_acc = prod[DATA_W-1:0];
            DP_DIV_FIX: n_acc = r_neg ? (~r_quo + 1'b1) : r_quo;
            default:    n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_acc <= n_acc;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind <= i_kind;
            r_opnd <= i_operand;
        end
        if (i_cmd.op == DP_DIV_INIT) begin
            r_rem <= '0;
            r_quo <= acc_mag;
            r_den <= opnd_mag;
            r_neg <= r_acc[DATA_W-1] ^ r_opnd[DATA_W-1];
            r_cnt <= '0;
        end else if (i_cmd.op == DP_DIV_STEP) begin
            r_rem <= fits ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
            r_quo <= {r_quo[DATA_W-2:0], fits};
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.emit) begin
            r_out_value <= i_cmd.emit_err ? '0 : r_acc;
            r_out_err   <= i_cmd.emit_err;
        end
    end

    assign o_status.kind      = t_kind'(r_kind);
    assign o_status.opnd_zero = (r_opnd == '0);
    assign o_status.div_last  = (r_cnt == CNT_W'(DATA_W - 1));
    assign o_status.out_free  = !r_out_valid || i_ready;

    assign o_valid = r_out_valid;
    assign o_value = r_out_value;
    assign o_error = r_out_err;

    // a new result never overwrites one still waiting
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_ready))
        else $error("result register overwritten");

    // error results carry a zero value
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_err) |-> (r_out_value == '0))
        else $error("error result with nonzero value");

endmodule

`default_nettype wire

### hw/rtl/chained_integer_calculator.sv
`default_nettype none

// channel   dir  tdata                  tuser
// s_axis    in   [31:0] operand (s32)   [2:0] kind
// m_axis    out  [31:0] value (s32)     [0] error
//
// one item at a time; s_axis_tready is high only while the block is idle
// load, add, subtract, multiply and ignored items: accept, then execute
// divide: accept, execute, then the shift-subtract divider (32 quotient
// bits, one per cycle, then a sign fix-up step); divide by zero is an error item
// equals and error items: accept, execute, emit, plus any wait for the result register
// the result register holds one item; a stalled m_axis holds back only an
// item that emits a result
// synchronous active-low reset closes the expression and clears the accumulator

module chained_integer_calculator (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [cic_pkg::DATA_W-1:0]   s_axis_tdata,  // [31:0] operand
    input  wire logic [cic_pkg::KIND_W-1:0]   s_axis_tuser,  // [2:0] kind
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic [cic_pkg::DATA_W-1:0]        m_axis_tdata,  // [31:0] value
    output logic [0:0]                        m_axis_tuser   // [0] error
);
    import cic_pkg::*;

    t_cmd                     cmd;
    t_status                  status;
    logic signed [DATA_W-1:0] value;
    logic                     error;

    // sequencer: decode, divide iterations, result hand-off
    cic_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // accumulator, multiplier, divider and result register
    cic_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_kind    (s_axis_tuser),
        .i_operand (s_axis_tdata),
        .i_cmd     (cmd),
        .o_status  (status),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_value   (value),
        .o_error   (error)
    );

    assign m_axis_tdata    = value;
    assign m_axis_tuser[0] = error;

endmodule

`default_nettype wire
